// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UULD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UULD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/uuld_pkg.sv -----
// Shared types, constants and helpers for the uudecode line decoder.
// No dependencies; used by uu_line_decoder, uuld_checker, uu_decode_checker and tb_top.
package uuld_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SHIFT,
        ST_TAIL
    } uuld_state_t;

    localparam logic [31:0] CAP_RESET   = 32'hFFFF_FFFF;
    localparam logic [7:0]  CHAR_LF     = 8'h0A;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_OFFSET = 8'd32;
    localparam logic        KIND_DATA   = 1'b0;
    localparam logic        KIND_FINISH = 1'b1;

    // (byte - 32) & 0x3f
    function automatic logic [5:0] sextet(input logic [7:0] b);
        logic [7:0] d;
        d = b - CHAR_OFFSET;
        return d[5:0];
    endfunction

endpackage

// ----- rtl/uu_line_decoder.sv -----
// uu_line_decoder: streaming uudecode, one encoded byte per input beat.
// Depends on uuld_pkg.
//
//  Channel | Dir | Beat carries
//  --------+-----+-----------------------------------------------------------
//  s_      | in  | tdata[7:0] encoded byte, tlast end of encoded buffer
//  m_      | out | tdata[7:0] decoded byte, tdata[39:8] running total,
//          |     | tuser result kind (data / finish), tlast last of input beat
//  cfg_    | in  | output capacity, written while cfg_we is high
//
// Steps: each input beat is accepted, then takes a header step and a tail step;
//   a body byte also passes once through the shift unit, a short line closed
//   by CR/LF is padded out there with zero sextets, and end of input inside an
//   open line pads it out from the tail step before the finish report.
// The shared 12-bit shift/extract unit does one sextet per cycle unless stalled.
// Reset (aresetn low, synchronous): decoder state cleared, capacity all ones.
// A result waits in the output register; shift and finish steps hold while it
// is full and not taken. The next beat is accepted while a result still waits.
module uu_line_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] total_bytes
    output logic        m_tuser,   // result_kind
    output logic        m_tlast,   // last_of_run
    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata  // output_capacity
);
    import uuld_pkg::*;

    uuld_state_t state_reg, state_next;

    // latched input beat
    logic [7:0]  byte_reg;
    logic        eoi_reg;
    logic [7:0]  byte_next;
    logic        eoi_next;

    // decoder state
    logic [31:0] cap_reg, cap_next;
    logic        in_body_reg, in_body_next;
    logic        fin_reg, fin_next;
    logic [5:0]  left_reg, left_next;
    logic [5:0]  buf_reg, buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] emitted_reg, emitted_next;
    logic        pad_reg, pad_next;   // padding a closed line with zero sextets

    // output register
    logic        m_valid_reg, m_valid_next;
    logic        m_kind_reg, m_kind_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic [31:0] m_total_reg, m_total_next;
    logic        m_last_reg, m_last_next;

    // shared shift unit
    logic [5:0]  sext;
    logic [11:0] acc;
    logic [3:0]  cnt_sum;
    logic        full;
    logic [2:0]  rem_bits;
    logic [11:0] keep_mask;
    logic [7:0]  ext_byte;
    logic [5:0]  buf_new;

    logic        out_free;
    logic        is_eol;
    logic [5:0]  nb;
    logic        cap_hit;
    logic [31:0] emitted_inc;
    logic [31:0] room;
    logic [5:0]  clamp_len;
    logic        active;
    logic [5:0]  left_dec;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_byte_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign is_eol   = (byte_reg == CHAR_LF) || (byte_reg == CHAR_CR);
    assign nb       = sextet(byte_reg);

    // capacity checks and line-length clamp
    assign cap_hit     = (emitted_reg >= cap_reg);
    assign emitted_inc = emitted_reg + 32'd1;
    assign room        = cap_reg - emitted_reg;
    assign clamp_len   = ((room[31:6] == 26'd0) && (room[5:0] < nb)) ? room[5:0] : nb;

    // one sextet into the bit buffer; a byte comes out once 8 bits are there
    assign sext      = pad_reg ? 6'd0 : nb;
    assign acc       = {buf_reg, sext};
    assign cnt_sum   = {1'b0, cnt_reg} + 4'd6;
    assign full      = cnt_sum[3];
    assign rem_bits  = cnt_sum[2:0];
    assign keep_mask = (12'd1 << rem_bits) - 12'd1;
    assign ext_byte  = 8'(acc >> rem_bits);
    assign buf_new   = full ? acc[5:0] & keep_mask[5:0] : acc[5:0];

    assign active   = in_body_reg && (left_reg != 6'd0) && !fin_reg;
    assign left_dec = left_reg - 6'd1;

    always_comb begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        eoi_next     = eoi_reg;
        cap_next     = cfg_we ? cfg_wdata : cap_reg;
        in_body_next = in_body_reg;
        fin_next     = fin_reg;
        left_next    = left_reg;
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        emitted_next = emitted_reg;
        pad_next     = pad_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_byte_next  = m_byte_reg;
        m_total_next = m_total_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    byte_next  = s_tdata;
                    eoi_next   = s_tlast;
                    state_next = ST_HEAD;
                end
            end

            ST_HEAD: begin
                state_next = ST_TAIL;
                if (!fin_reg) begin
                    if (!in_body_reg) begin
                        // length byte; CR/LF before a line are skipped
                        if (!is_eol) begin
                            if (nb == 6'd0 || cap_hit) begin
                                fin_next = 1'b1;
                            end else begin
                                left_next    = clamp_len;
                                in_body_next = 1'b1;
                                buf_next     = 6'd0;
                                cnt_next     = 3'd0;
                            end
                        end
                    end else if (is_eol) begin
                        if (left_reg != 6'd0) begin
                            pad_next   = 1'b1;
                            state_next = ST_SHIFT;
                        end else begin
                            in_body_next = 1'b0;
                            buf_next     = 6'd0;
                            cnt_next     = 3'd0;
                        end
                    end else begin
                        pad_next   = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT: begin
                if (out_free) begin
                    if (active) begin
                        if (full) begin
                            if (cap_hit) begin
                                fin_next = 1'b1;
                            end else begin
                                emitted_next = emitted_inc;
                                left_next    = left_dec;
                                if (emitted_inc == cap_reg) begin
                                    fin_next = 1'b1;
                                end
                                if (left_dec == 6'd0) begin
                                    buf_next = 6'd0;
                                    cnt_next = 3'd0;
                                end else begin
                                    buf_next = buf_new;
                                    cnt_next = rem_bits;
                                end
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_DATA;
                                m_byte_next  = ext_byte;
                                m_total_next = emitted_inc;
                                // more results follow on end of input or while padding
                                m_last_next  = !(eoi_reg || (pad_reg && (left_dec != 6'd0)
                                                 && (emitted_inc != cap_reg)));
                            end
                        end else begin
                            buf_next = buf_new;
                            cnt_next = rem_bits;
                        end
                    end
                    if (pad_reg) begin
                        if (!(in_body_next && (left_next != 6'd0) && !fin_next)) begin
                            // line closed: drop leftover bits
                            in_body_next = 1'b0;
                            left_next    = 6'd0;
                            buf_next     = 6'd0;
                            cnt_next     = 3'd0;
                            pad_next     = 1'b0;
                            state_next   = ST_TAIL;
                        end
                    end else begin
                        state_next = ST_TAIL;
                    end
                end
            end

            ST_TAIL: begin
                if (eoi_reg && in_body_reg && !fin_reg && (left_reg != 6'd0)) begin
                    pad_next   = 1'b1;
                    state_next = ST_SHIFT;
                end else if (eoi_reg) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_FINISH;
                        m_byte_next  = 8'd0;
                        m_total_next = emitted_reg;
                        m_last_next  = 1'b1;
                        in_body_next = 1'b0;
                        fin_next     = 1'b0;
                        left_next    = 6'd0;
                        buf_next     = 6'd0;
                        cnt_next     = 3'd0;
                        emitted_next = 32'd0;
                        pad_next     = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            in_body_reg <= 1'b0;
            fin_reg     <= 1'b0;
            left_reg    <= 6'd0;
            buf_reg     <= 6'd0;
            cnt_reg     <= 3'd0;
            emitted_reg <= 32'd0;
            pad_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            in_body_reg <= in_body_next;
            fin_reg     <= fin_next;
            left_reg    <= left_next;
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            emitted_reg <= emitted_next;
            pad_reg     <= pad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        eoi_reg     <= eoi_next;
        m_kind_reg  <= m_kind_next;
        m_byte_reg  <= m_byte_next;
        m_total_reg <= m_total_next;
        m_last_reg  <= m_last_next;
    end

endmodule

// ----- rtl/uuld_checker.sv -----
// Port-level checks for uu_line_decoder, bound into every uu_line_decoder instance.
// Depends on uuld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uuld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import uuld_pkg::*;

    // stalled result beat holds
    `UULD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    // finish report: zero byte, always last of its input beat
    `UULD_ASSERT_NOW(a_finish_form, aclk, aresetn, m_tvalid && (m_tuser == KIND_FINISH), (m_tdata[7:0] == 8'd0) && m_tlast, "bad finish report")

    // a data beat counts itself
    `UULD_ASSERT_NOW(a_data_total, aclk, aresetn, m_tvalid && (m_tuser == KIND_DATA), m_tdata[39:8] != 32'd0, "data beat with zero total")

    // the decoder is not ready in the cycle after it accepts a beat
    `UULD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

bind uu_line_decoder uuld_checker u_uuld_checker (.*);

// ----- bench/uu_decode_checker.sv -----
// Checker for the uudecode line decoder: watches the input, result and config ports,
// predicts the decoded bytes and finish reports, and compares each result beat.
// Depends on uuld_pkg.
module uu_decode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] total_bytes
    input  logic        m_tuser,   // result_kind
    input  logic        m_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata, // output_capacity
    output int          fail_count,
    output int          results_pending
);
    import uuld_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [31:0] total;
        logic        last;
    } decoded_t;

    decoded_t    decoded_q[$];
    int          mismatches = 0;
    int          waiting = 0;

    // decoder shadow state
    logic [31:0] capacity;
    logic        in_body;
    logic        finished;
    logic [5:0]  bytes_left;
    logic [5:0]  bits;
    logic [2:0]  nbits;
    logic [31:0] emitted;

    assign fail_count      = mismatches;
    assign results_pending = waiting;

    function automatic logic [5:0] sextet_of(input logic [7:0] b);
        logic [7:0] diff;
        diff = b + 8'd224;
        return diff[5:0];
    endfunction

    task automatic clear_stream();
        in_body    = 1'b0;
        finished   = 1'b0;
        bytes_left = '0;
        bits       = '0;
        nbits      = '0;
        emitted    = '0;
    endtask

    task automatic push_result(input logic kind, input logic [7:0] data,
                               input logic [31:0] total);
        decoded_t r;
        r.kind  = kind;
        r.data  = data;
        r.total = total;
        r.last  = 1'b0;
        decoded_q.push_back(r);
    endtask

    task automatic shift_sextet(input logic [5:0] s);
        logic [11:0] acc;
        logic [3:0]  cnt;
        if (!in_body || bytes_left == 0 || finished)
            return;
        acc = {bits, s};
        cnt = 4'(nbits) + 4'd6;
        if (cnt >= 4'd8) begin
            cnt = cnt - 4'd8;
            if (emitted >= capacity) begin
                finished = 1'b1;
                return;
            end
            emitted = emitted + 1;
            push_result(KIND_DATA, 8'(acc >> cnt), emitted);
            acc = acc & ((12'd1 << cnt) - 12'd1);
            bytes_left = bytes_left - 1;
            if (emitted >= capacity)
                finished = 1'b1;
            if (bytes_left == 0) begin
                acc = '0;
                cnt = '0;
            end
        end
        bits  = acc[5:0];
        nbits = cnt[2:0];
    endtask

    // pad a short line with zero sextets, then drop whatever is left
    task automatic close_line();
        while (in_body && bytes_left > 0 && !finished)
            shift_sextet(6'd0);
        in_body    = 1'b0;
        bytes_left = '0;
        bits       = '0;
        nbits      = '0;
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic eoi);
        int          first;
        logic        is_eol;
        logic [5:0]  n;
        logic [31:0] room;
        decoded_t    tail;
        first  = decoded_q.size();
        is_eol = (b == CHAR_LF) || (b == CHAR_CR);
        if (!finished) begin
            if (!in_body) begin
                if (!is_eol) begin
                    n = sextet_of(b);
                    if (n == 0 || emitted >= capacity) begin
                        finished = 1'b1;
                    end else begin
                        room       = capacity - emitted;
                        bytes_left = ({26'd0, n} < room) ? n : room[5:0];
                        in_body    = 1'b1;
                        bits       = '0;
                        nbits      = '0;
                    end
                end
            end else if (is_eol) begin
                close_line();
            end else begin
                shift_sextet(sextet_of(b));
            end
            if (eoi && in_body && !finished)
                close_line();
        end
        if (eoi) begin
            push_result(KIND_FINISH, 8'd0, emitted);
            clear_stream();
        end
        if (decoded_q.size() > first) begin
            tail      = decoded_q.pop_back();
            tail.last = 1'b1;
            decoded_q.push_back(tail);
        end
    endtask

    task automatic report(input string what, input decoded_t want, input decoded_t got);
        if (mismatches < 10)
            $display("%s: expected kind %0d byte %02h total %0d last %0d, got kind %0d byte %02h total %0d last %0d",
                     what, want.kind, want.data, want.total, want.last,
                     got.kind, got.data, got.total, got.last);
        mismatches++;
    endtask

    task automatic check_result();
        decoded_t want;
        decoded_t got;
        got.kind  = m_tuser;
        got.data  = m_tdata[7:0];
        got.total = m_tdata[39:8];
        got.last  = m_tlast;
        if (decoded_q.size() == 0) begin
            report("unexpected result", '0, got);
        end else begin
            want = decoded_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.total !== want.total || got.last !== want.last)
                report("result mismatch", want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            capacity = CAP_RESET;
            clear_stream();
            decoded_q.delete();
        end else begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_beat(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        waiting <= decoded_q.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the uu_line_decoder bench: clock, reset, encoded-text stimulus and verdict.
// Depends on uuld_pkg, uu_line_decoder and uu_decode_checker.
module tb_top;
    import uuld_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int DRAIN_CYCLES   = 100;      // longest padding run plus margin
    localparam int RANDOM_BEATS   = 300;
    localparam int TIMEOUT_CYCLES = 4_000_000;

    typedef enum int {
        END_LF,
        END_CR,
        END_CRLF,
        END_NONE
    } line_end_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    int          fail_count;
    int          results_pending;

    // encoded text waiting to go out, one byte per beat
    logic [7:0]  text_q[$];
    int          beats_sent = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_stalls = 1'b1;
    int          rx_hold = 0;

    uu_line_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    uu_decode_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // hard stop in case the decoder hangs
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result-side backpressure; rx_stalls off gives stall-free stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rand_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Any byte whose (byte - 32) & 0x3f equals s; the upper bits are random so
    // every bit of in_byte toggles. CR/LF aliases are moved up by 0x80 so a
    // body byte never closes the line by accident.
    function automatic logic [7:0] encode_sextet(input logic [5:0] s);
        logic [1:0] k;
        logic [7:0] b;
        k = 2'($urandom_range(0, 3));
        b = CHAR_OFFSET + {2'b00, s} + {k, 6'b0};
        if (b == CHAR_LF || b == CHAR_CR)
            b = b ^ 8'h80;
        return b;
    endfunction

    // line length: mostly short, now and then up to the 63-byte maximum
    function automatic int line_size();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(13, 63);
        return $urandom_range(1, 12);
    endfunction

    function automatic line_end_t rand_end();
        return line_end_t'($urandom_range(0, 2));
    endfunction

    // one beat: optional gap, then hold tvalid until accepted; tvalid stays up
    // afterwards so the next beat can follow with no bubble
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_gaps ? rand_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // length byte, body sextets, then the chosen line ending
    task automatic add_line(input int n, input int body, input line_end_t ending);
        text_q.push_back(encode_sextet(6'(n)));
        repeat (body) text_q.push_back(encode_sextet(6'($urandom_range(0, 63))));
        case (ending)
            END_LF: text_q.push_back(CHAR_LF);
            END_CR: text_q.push_back(CHAR_CR);
            END_CRLF: begin
                text_q.push_back(CHAR_CR);
                text_q.push_back(CHAR_LF);
            end
            default: ;
        endcase
    endtask

    // send the queued text; close_buf puts tlast on its final byte
    task automatic flush_text(input bit close_buf);
        logic [7:0] b;
        while (text_q.size() > 0) begin
            b = text_q.pop_front();
            send_beat(b, close_buf && text_q.size() == 0);
        end
    endtask

    // Stop sending, wait until every predicted result is out, then give the
    // decoder time to finish any padding that produces nothing we expect.
    // The first edge lets the checker count the last accepted beat.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // A few lines of mostly well-formed text with random content. The rest
    // is truncated lines (padded out), overlong lines (tail ignored) and
    // junk. The buffer ends on a line end, inside an open line, or after a
    // zero-length terminator line followed by trailing bytes.
    task automatic build_buffer();
        int lines;
        int kind;
        int n;
        int full;
        lines = $urandom_range(1, 4);
        for (int i = 0; i < lines; i++) begin
            if ($urandom_range(0, 9) == 0)
                text_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            n    = line_size();
            full = 4 * ((n + 2) / 3);
            kind = $urandom_range(0, 99);
            if (kind < 70)
                add_line(n, full, rand_end());
            else if (kind < 80)
                add_line(n, $urandom_range(0, full - 1), rand_end());
            else if (kind < 90)
                add_line(n, full + $urandom_range(1, 6), rand_end());
            else
                repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom));
        end
        case ($urandom_range(0, 3))
            0: begin
                n = line_size();
                add_line(n, $urandom_range(0, 4 * ((n + 2) / 3)), END_NONE);
            end
            1: begin
                add_line(0, 0, END_LF);
                repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    initial begin
        int         random_start;
        logic [31:0] cap;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part, capacity at its reset value (all ones) ---
        // blank lines skipped, then a 3-byte line with extreme body bytes
        text_q = '{CHAR_CR, CHAR_LF, 8'h23, 8'h20, 8'hFF, 8'h00, 8'h7F, CHAR_LF};
        // 63-byte line closed by CR after one body byte: long zero padding
        text_q.push_back(8'h5F);
        text_q.push_back(8'hBF);
        text_q.push_back(CHAR_CR);
        // length byte 0x00 decodes to 32; end of input inside the line
        text_q.push_back(8'h00);
        text_q.push_back(8'h80);
        text_q.push_back(8'h41);
        flush_text(1'b1);
        // empty buffer: end of input on a bare LF gives a zero-total report
        send_beat(CHAR_LF, 1'b1);

        // clamp: 10-byte line cut to 5, then capacity reached, then a zero
        // length byte and trailing text ignored until end of input
        set_capacity(32'd5);
        add_line(10, 1, END_LF);
        text_q.push_back(8'h60);
        text_q.push_back(8'hFF);
        flush_text(1'b1);

        // capacity zero lets nothing out
        set_capacity(32'd0);
        add_line(1, 1, END_NONE);
        flush_text(1'b1);

        // capacity lowered in the middle of an open line
        set_capacity(CAP_RESET);
        add_line(20, 4, END_NONE);
        flush_text(1'b0);
        set_capacity(32'd4);
        add_line(0, 0, END_NONE);
        text_q.delete();
        text_q.push_back(encode_sextet(6'd63));
        text_q.push_back(CHAR_LF);
        text_q.push_back(8'h21);
        flush_text(1'b1);

        // --- random part: one buffer per capacity setting ---
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            case ($urandom_range(0, 7))
                0: cap = CAP_RESET;
                1: cap = 32'd1;
                2: cap = 32'd0;
                3, 4: cap = 32'($urandom_range(2, 30));
                5: cap = $urandom;
                default: cap = 32'($urandom_range(31, 400));
            endcase
            set_capacity(cap);
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            build_buffer();
            flush_text(1'b1);
        end

        drain();
        if (fail_count == 0 && results_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
